@@ design/smcp_pkg.sv @@
// smcp_pkg: shared types and constants for the serial motor command parser.
// No dependencies; used by smcp_line_parser, smcp_result_stage and serial_motor_command_parser.
package smcp_pkg;

  localparam int LINE_CAPACITY = 63;
  localparam int KEPT_W = $clog2(LINE_CAPACITY + 1);
  localparam logic [KEPT_W-1:0] KEPT_MAX = KEPT_W'(LINE_CAPACITY);

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;

  localparam logic [2:0] PREFIX_DONE = 3'd4;
  localparam logic [2:0] PREFIX_BAD  = 3'd7;

  localparam logic [31:0] MAG_SAT     = 32'hFFFF_FFFF;
  localparam logic [31:0] POS_LIMIT   = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT   = 32'h8000_0000;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_NUM  = 2'd1,
    PH_STOP = 2'd2
  } phase_t;

  // finished command line, handed to the result stage
  typedef struct packed {
    logic        valid;
    logic        left_neg;
    logic [31:0] left_mag;
    logic        right_neg;
    logic [31:0] right_mag;
  } line_res_t;

  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h43; // C
      2'd1:    c = 8'h4D; // M
      2'd2:    c = 8'h44; // D
      default: c = 8'h3A; // :
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
  endfunction

endpackage

@@ design/smcp_if.sv @@
// smcp_if: valid/ready channel interfaces for received bytes and parsed commands.
// Depends on nothing; instantiated around serial_motor_command_parser.
interface smcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface smcp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_value;
  logic signed [31:0] right_value;
  logic               clipped;

  modport source (output valid, output left_value, output right_value, output clipped,
                  input ready);
  modport sink   (input valid, input left_value, input right_value, input clipped,
                  output ready);
endinterface

@@ design/smcp_line_parser.sv @@
// smcp_line_parser: per-byte line state, prefix match and atoi accumulators.
// Depends on smcp_pkg.
module smcp_line_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  output smcp_pkg::line_res_t   line_res
);

  logic [smcp_pkg::KEPT_W-1:0] kept_count_r, kept_count_nxt;
  logic [2:0]                  prefix_r, prefix_nxt;
  logic                        ended_r, ended_nxt;
  logic                        comma_r, comma_nxt;
  smcp_pkg::phase_t            phase_r, phase_nxt;
  logic                        lneg_r, lneg_nxt, rneg_r, rneg_nxt;
  logic [31:0]                 lmag_r, lmag_nxt, rmag_r, rmag_nxt;

  logic        cur_neg, new_neg;
  logic [31:0] cur_mag, new_mag;
  logic [35:0] prod;
  logic        is_digit;

  assign cur_neg  = comma_r ? rneg_r : lneg_r;
  assign cur_mag  = comma_r ? rmag_r : lmag_r;
  assign is_digit = (rx_byte >= smcp_pkg::CHAR_ZERO) && (rx_byte <= smcp_pkg::CHAR_NINE);
  // mag * 10 + digit
  assign prod = {1'b0, cur_mag, 3'b000} + {3'b000, cur_mag, 1'b0}
              + {32'd0, rx_byte[3:0]};

  always_comb begin
    kept_count_nxt = kept_count_r;
    prefix_nxt     = prefix_r;
    ended_nxt      = ended_r;
    comma_nxt      = comma_r;
    phase_nxt      = phase_r;
    lneg_nxt       = lneg_r;
    lmag_nxt       = lmag_r;
    rneg_nxt       = rneg_r;
    rmag_nxt       = rmag_r;
    new_neg        = cur_neg;
    new_mag        = cur_mag;

    line_res.valid     = step && (rx_byte == smcp_pkg::CHAR_NEWLINE)
                         && (prefix_r == smcp_pkg::PREFIX_DONE) && comma_r;
    line_res.left_neg  = lneg_r;
    line_res.left_mag  = lmag_r;
    line_res.right_neg = rneg_r;
    line_res.right_mag = rmag_r;

    // number feed on the active side
    if (phase_r != smcp_pkg::PH_STOP) begin
      if (phase_r == smcp_pkg::PH_SKIP && smcp_pkg::is_space(rx_byte)) begin
        phase_nxt = phase_r;
      end else if (phase_r == smcp_pkg::PH_SKIP && rx_byte == smcp_pkg::CHAR_MINUS) begin
        phase_nxt = smcp_pkg::PH_NUM;
        new_neg   = 1'b1;
      end else if (phase_r == smcp_pkg::PH_SKIP && rx_byte == smcp_pkg::CHAR_PLUS) begin
        phase_nxt = smcp_pkg::PH_NUM;
      end else if (is_digit) begin
        phase_nxt = smcp_pkg::PH_NUM;
        new_mag   = (prod[35:32] != 4'd0) ? smcp_pkg::MAG_SAT : prod[31:0];
      end else begin
        phase_nxt = smcp_pkg::PH_STOP;
      end
    end

    if (rx_byte == smcp_pkg::CHAR_NEWLINE) begin
      kept_count_nxt = '0;
      prefix_nxt     = 3'd0;
      ended_nxt      = 1'b0;
      comma_nxt      = 1'b0;
      phase_nxt      = smcp_pkg::PH_SKIP;
      lneg_nxt       = 1'b0;
      lmag_nxt       = '0;
      rneg_nxt       = 1'b0;
      rmag_nxt       = '0;
    end else if (kept_count_r >= smcp_pkg::KEPT_MAX || ended_r) begin
      phase_nxt = phase_r;
    end else begin
      kept_count_nxt = kept_count_r + 1'b1;
      if (rx_byte == smcp_pkg::CHAR_NUL) begin
        ended_nxt = 1'b1;
        phase_nxt = phase_r;
      end else if (prefix_r < smcp_pkg::PREFIX_DONE) begin
        prefix_nxt = (rx_byte == smcp_pkg::prefix_char(prefix_r[1:0]))
                     ? prefix_r + 3'd1 : smcp_pkg::PREFIX_BAD;
        phase_nxt  = phase_r;
      end else if (prefix_r != smcp_pkg::PREFIX_DONE) begin
        phase_nxt = phase_r;
      end else if (!comma_r && rx_byte == smcp_pkg::CHAR_COMMA) begin
        comma_nxt = 1'b1;
        phase_nxt = smcp_pkg::PH_SKIP;
      end else if (comma_r) begin
        rneg_nxt = new_neg;
        rmag_nxt = new_mag;
      end else begin
        lneg_nxt = new_neg;
        lmag_nxt = new_mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_count_r <= '0;
      prefix_r     <= 3'd0;
      ended_r      <= 1'b0;
      comma_r      <= 1'b0;
      phase_r      <= smcp_pkg::PH_SKIP;
      lneg_r       <= 1'b0;
      lmag_r       <= '0;
      rneg_r       <= 1'b0;
      rmag_r       <= '0;
    end else if (step) begin
      kept_count_r <= kept_count_nxt;
      prefix_r     <= prefix_nxt;
      ended_r      <= ended_nxt;
      comma_r      <= comma_nxt;
      phase_r      <= phase_nxt;
      lneg_r       <= lneg_nxt;
      lmag_r       <= lmag_nxt;
      rneg_r       <= rneg_nxt;
      rmag_r       <= rmag_nxt;
    end
  end

endmodule

@@ design/smcp_result_stage.sv @@
// smcp_result_stage: sign/saturate the two magnitudes and hold the output transaction.
// Depends on smcp_pkg and smcp_out_if.
module smcp_result_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  smcp_pkg::line_res_t line_res,
  output logic                res_free,
  smcp_out_if.source          out_ch
);

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] left_r, right_r, left_nxt, right_nxt;
  logic        clip_r, clip_nxt;
  logic        lclip, rclip;

  function automatic logic [31:0] to_value(input logic neg, input logic [31:0] mag);
    logic [31:0] v;
    if (neg) begin
      v = (mag > smcp_pkg::NEG_LIMIT) ? smcp_pkg::NEG_LIMIT : (32'd0 - mag);
    end else begin
      v = (mag > smcp_pkg::POS_LIMIT) ? smcp_pkg::POS_LIMIT : mag;
    end
    return v;
  endfunction

  function automatic logic over(input logic neg, input logic [31:0] mag);
    return neg ? (mag > smcp_pkg::NEG_LIMIT) : (mag > smcp_pkg::POS_LIMIT);
  endfunction

  assign res_free = !out_valid_r || out_ch.ready;
  assign lclip    = over(line_res.left_neg, line_res.left_mag);
  assign rclip    = over(line_res.right_neg, line_res.right_mag);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    left_nxt      = left_r;
    right_nxt     = right_r;
    clip_nxt      = clip_r;
    if (line_res.valid) begin
      out_valid_nxt = 1'b1;
      left_nxt      = to_value(line_res.left_neg, line_res.left_mag);
      right_nxt     = to_value(line_res.right_neg, line_res.right_mag);
      clip_nxt      = lclip || rclip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
    clip_r  <= clip_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_value  = left_r;
  assign out_ch.right_value = right_r;
  assign out_ch.clipped     = clip_r;

endmodule

@@ design/serial_motor_command_parser.sv @@
// serial_motor_command_parser: top level, input byte register plus parser and result stage.
// Depends on smcp_pkg, smcp_if, smcp_line_parser and smcp_result_stage.
//
// Takes one received byte per cycle. Each byte is registered on arrival and folded into the
// line state as it leaves the input register; a newline that closes a "CMD:<left>,<right>"
// line loads the output register when that newline leaves the input register. The byte path
// sustains one transaction per clock. The only stall comes from the output register: a newline
// waiting in the input register holds while an earlier result is not yet taken.
module serial_motor_command_parser (
  input  logic       clk,
  input  logic       rst_n,
  smcp_in_if.sink    in_ch,
  smcp_out_if.source out_ch
);

  logic                in_valid_r;
  logic [7:0]          in_byte_r;
  logic                res_free;
  logic                advance;
  logic                step;
  smcp_pkg::line_res_t line_res;

  assign advance     = !in_valid_r || (in_byte_r != smcp_pkg::CHAR_NEWLINE) || res_free;
  assign step        = in_valid_r && advance;
  assign in_ch.ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (advance) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  smcp_line_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .rx_byte  (in_byte_r),
    .line_res (line_res)
  );

  smcp_result_stage u_result (
    .clk      (clk),
    .rst_n    (rst_n),
    .line_res (line_res),
    .res_free (res_free),
    .out_ch   (out_ch)
  );

endmodule
